// ===== sv/plsu_pkg.sv =====
// Shared types, constants and helpers for the Phong light shading unit.
// Used by plsu_norm and phong_light_shader_unit; depends on nothing else.
package plsu_pkg;

    localparam int CMP_W = 21;          // packed Q10.10 component
    localparam int VEC_W = 22;          // difference vector component
    localparam int UNIT_W = 16;         // signed Q1.14 unit component
    localparam int ONE_Q14 = 16384;
    localparam int REFLECT_GAIN = 2;

    localparam int SQ_ITER = 22;        // root bits of a 44-bit sum of squares
    localparam int SQ_PER = 2;
    localparam int SQ_STG = (SQ_ITER + SQ_PER - 1) / SQ_PER;
    localparam int DV_ITER = 15;        // quotient bits, quotient <= 1.0 in Q1.14
    localparam int DV_PER = 3;
    localparam int DV_STG = (DV_ITER + DV_PER - 1) / DV_PER;
    localparam int NORM_LAT = 2 + SQ_STG + 1 + DV_STG + 1;

    localparam int LOG_ROUNDS = 16;
    localparam int EXP_TERMS = 16;

    typedef logic signed [VEC_W-1:0] vcmp_t;
    typedef logic signed [UNIT_W-1:0] ucmp_t;

    typedef struct packed {
        logic [62:0] surface_normal;
        logic [62:0] surface_position;
        logic [62:0] light_position;
        logic [62:0] ray_direction;
        logic [47:0] light_color;
        logic [47:0] material_ambient;
        logic [47:0] material_diffuse;
        logic [47:0] material_specular;
        logic [15:0] shininess;
    } in_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } out_t;

    // 2^(-2^-(idx+1)) in Q.16
    function automatic logic [15:0] exp2_neg(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd46341;
            4'd1:    v = 16'd55109;
            4'd2:    v = 16'd60097;
            4'd3:    v = 16'd62757;
            4'd4:    v = 16'd64132;
            4'd5:    v = 16'd64830;
            4'd6:    v = 16'd65182;
            4'd7:    v = 16'd65359;
            4'd8:    v = 16'd65447;
            4'd9:    v = 16'd65492;
            4'd10:   v = 16'd65514;
            4'd11:   v = 16'd65525;
            4'd12:   v = 16'd65530;
            4'd13:   v = 16'd65533;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // Sign-extended component i of a packed Q10.10 triple
    function automatic vcmp_t cmp_at(input logic [62:0] w, input int unsigned i);
        logic signed [CMP_W-1:0] c;
        c = $signed(w[CMP_W*i +: CMP_W]);
        return VEC_W'(c);
    endfunction

    // Arithmetic right shift by k, rounding half away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                   input int unsigned k);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q = (mag + (64'd1 << (k - 1))) >> k;
        return x[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== sv/plsu_norm.sv =====
// Pipelined vector normalizer: squares, digit-by-digit root, long division.
// Depends on plsu_pkg; the pipeline advances only while en is high.
module plsu_norm (
    input  logic            aclk,
    input  logic            en,
    input  plsu_pkg::vcmp_t vec   [3],
    output plsu_pkg::ucmp_t u_out [3]
);

    localparam int SQ_W = 46;
    localparam int M_W = 23;
    localparam int REM_W = M_W + 1;
    localparam int Q_W = plsu_pkg::DV_ITER;
    localparam int MAG_W = plsu_pkg::VEC_W;
    localparam int NUM_W = MAG_W + 15;
    localparam int VC_LEN = 2 + plsu_pkg::SQ_STG;
    localparam int TOP_BIT = 2 * (plsu_pkg::SQ_ITER - 1);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   low;
    } dv_t;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic           z;
        logic [2:0]     sg;
    } dvc_t;

    logic [43:0]     sq_reg [3];
    plsu_pkg::vcmp_t vc_reg [VC_LEN][3];
    logic [SQ_W-1:0] rt_rem_reg  [plsu_pkg::SQ_STG+1];
    logic [SQ_W-1:0] rt_root_reg [plsu_pkg::SQ_STG+1];
    logic [SQ_W-1:0] rt_rem_next  [plsu_pkg::SQ_STG+1];
    logic [SQ_W-1:0] rt_root_next [plsu_pkg::SQ_STG+1];
    dv_t             dv_reg  [plsu_pkg::DV_STG+1][3];
    dv_t             dv_next [plsu_pkg::DV_STG+1][3];
    dvc_t            dvc_reg [plsu_pkg::DV_STG+1];
    dvc_t            dvc_next;
    plsu_pkg::ucmp_t u_reg [3];
    plsu_pkg::ucmp_t u_next [3];

    // Root: two bit pairs per stage
    always_comb begin
        logic [SQ_W-1:0] rem_v;
        logic [SQ_W-1:0] root_v;
        logic [SQ_W-1:0] bt;
        rt_rem_next[0] = SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        rt_root_next[0] = '0;
        for (int j = 1; j <= plsu_pkg::SQ_STG; j++) begin
            rem_v = rt_rem_reg[j-1];
            root_v = rt_root_reg[j-1];
            for (int q = 0; q < plsu_pkg::SQ_PER; q++) begin
                if ((j - 1) * plsu_pkg::SQ_PER + q < plsu_pkg::SQ_ITER) begin
                    bt = SQ_W'(1) << (TOP_BIT - 2 * ((j - 1) * plsu_pkg::SQ_PER + q));
                    if (rem_v >= root_v + bt) begin
                        rem_v = rem_v - (root_v + bt);
                        root_v = (root_v >> 1) + bt;
                    end else begin
                        root_v = root_v >> 1;
                    end
                end
            end
            rt_rem_next[j] = rem_v;
            rt_root_next[j] = root_v;
        end
    end

    // Divider set-up, then restoring division, then sign and clamp
    always_comb begin
        logic [M_W-1:0]   m_v;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] num;
        dv_t              cur;
        logic             qb;
        logic [Q_W-1:0]   qc;
        m_v = M_W'(rt_root_reg[plsu_pkg::SQ_STG]);
        dvc_next.m = m_v;
        dvc_next.z = (m_v == '0);
        for (int i = 0; i < 3; i++) begin
            dvc_next.sg[i] = vc_reg[VC_LEN-1][i][MAG_W-1];
            mag = vc_reg[VC_LEN-1][i][MAG_W-1] ? MAG_W'(-vc_reg[VC_LEN-1][i])
                                               : MAG_W'(vc_reg[VC_LEN-1][i]);
            num = (NUM_W'(mag) << 14) + NUM_W'(m_v >> 1);
            dv_next[0][i].rem = REM_W'(num >> Q_W);
            dv_next[0][i].q = '0;
            dv_next[0][i].low = num[Q_W-1:0];
        end
        for (int j = 1; j <= plsu_pkg::DV_STG; j++) begin
            for (int i = 0; i < 3; i++) begin
                cur = dv_reg[j-1][i];
                for (int q = 0; q < plsu_pkg::DV_PER; q++) begin
                    if ((j - 1) * plsu_pkg::DV_PER + q < plsu_pkg::DV_ITER) begin
                        cur.rem = {cur.rem[REM_W-2:0],
                                   cur.low[Q_W-1-((j-1)*plsu_pkg::DV_PER+q)]};
                        qb = (cur.rem >= REM_W'(dvc_reg[j-1].m));
                        if (qb) begin
                            cur.rem = cur.rem - REM_W'(dvc_reg[j-1].m);
                        end
                        cur.q = {cur.q[Q_W-2:0], qb};
                    end
                end
                dv_next[j][i] = cur;
            end
        end
        for (int i = 0; i < 3; i++) begin
            qc = dv_reg[plsu_pkg::DV_STG][i].q;
            if (qc > Q_W'(plsu_pkg::ONE_Q14)) begin
                qc = Q_W'(plsu_pkg::ONE_Q14);
            end
            if (dvc_reg[plsu_pkg::DV_STG].z) begin
                u_next[i] = '0;
            end else if (dvc_reg[plsu_pkg::DV_STG].sg[i]) begin
                u_next[i] = -$signed(plsu_pkg::UNIT_W'(qc));
            end else begin
                u_next[i] = $signed(plsu_pkg::UNIT_W'(qc));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 44'(44'(vec[i]) * 44'(vec[i]));
                vc_reg[0][i] <= vec[i];
                u_reg[i] <= u_next[i];
            end
            for (int s = 1; s < VC_LEN; s++) begin
                vc_reg[s] <= vc_reg[s-1];
            end
            for (int j = 0; j <= plsu_pkg::SQ_STG; j++) begin
                rt_rem_reg[j] <= rt_rem_next[j];
                rt_root_reg[j] <= rt_root_next[j];
            end
            dvc_reg[0] <= dvc_next;
            for (int j = 1; j <= plsu_pkg::DV_STG; j++) begin
                dvc_reg[j] <= dvc_reg[j-1];
            end
            dv_reg <= dv_next;
        end
    end

    assign u_out = u_reg;

endmodule

// ===== sv/phong_light_shader_unit.sv =====
// Phong light shading unit: top level, full shading pipeline and output skid.
// Depends on plsu_pkg and plsu_norm.
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+-------------------
//  input    | s_valid, s_ready, s_data       | in        | plsu_pkg::in_t
//  result   | m_valid, m_ready, m_data       | out       | plsu_pkg::out_t
//  config   | cfg_wr_en, cfg_wr_data         | in        | scene ambient RGB
//
// One item is accepted per cycle while s_ready is high; each item yields one
// result, the pipeline depth being set by the root and divider stages of
// the normalizers and the 16 squaring and 16 exp2 product stages.
// aresetn is synchronous, active low; it clears valid bits, the output
// stage and the scene ambient register. A stalled result is held in the
// output register while one more item drains into a skid entry; only then
// does the pipeline freeze and s_ready drop.
module phong_light_shader_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  plsu_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output plsu_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic [47:0]     cfg_wr_data
);

    // Stage positions, counted from the input register at 0
    localparam int S_N = plsu_pkg::NORM_LAT;     // unit normal and light dir
    localparam int S_D1 = S_N + 1;               // N.L partial products
    localparam int S_D2 = S_N + 2;               // N.L in Q2.28
    localparam int S_D3 = S_N + 3;               // diffuse, reflect products
    localparam int S_D4 = S_N + 4;               // reflected vector R
    localparam int S_D5 = S_N + 5;               // V.R partial products
    localparam int S_D6 = S_N + 6;               // V.R sum
    localparam int S_D7 = S_N + 7;               // specular base
    localparam int S_P0 = S_D7 + 1;              // log2 normalize
    localparam int S_LG = S_P0 + plsu_pkg::LOG_ROUNDS;
    localparam int S_NL = S_LG + 1;              // exponent product
    localparam int S_EX = S_NL + plsu_pkg::EXP_TERMS;
    localparam int S_EF = S_EX + 1;              // specular factor
    localparam int S_C1 = S_EF + 1;
    localparam int S_C2 = S_EF + 2;
    localparam int S_C3 = S_EF + 3;
    localparam int S_C4 = S_EF + 4;              // result
    localparam int DEPTH = S_C4 + 1;

    typedef struct packed {
        logic [2:0][31:0] amb;
        logic [2:0][15:0] lc;
        logic [2:0][15:0] kd;
        logic [2:0][15:0] ks;
        logic [2:0][15:0] v;
        logic [15:0]      e;
    } side_t;

    typedef struct packed {
        logic [14:0] y;
        logic [15:0] f;
        logic [3:0]  k;
        logic        fz;
        logic        fo;
    } pw_t;

    typedef struct packed {
        logic [30:0] acc;
        logic [15:0] fp;
        logic [3:0]  ip;
        logic        fz;
        logic        fo;
    } ex_t;

    logic                en;
    logic                s_take;
    logic [47:0]         scene_amb_reg;
    logic [DEPTH-1:0]    vld_reg;
    side_t               sd_reg [DEPTH];
    side_t               sd_next;
    plsu_pkg::vcmp_t     nv_reg [3];
    plsu_pkg::vcmp_t     lv_reg [3];
    plsu_pkg::vcmp_t     nv_next [3];
    plsu_pkg::vcmp_t     lv_next [3];
    plsu_pkg::ucmp_t     n_u [3];
    plsu_pkg::ucmp_t     l_u [3];
    plsu_pkg::ucmp_t     n_d1_reg [3];
    plsu_pkg::ucmp_t     n_d2_reg [3];
    plsu_pkg::ucmp_t     l_d1_reg [3];
    plsu_pkg::ucmp_t     l_d2_reg [3];
    plsu_pkg::ucmp_t     l_d3_reg [3];
    logic signed [31:0]  nl_prod_reg [3];
    logic signed [31:0]  d28_reg;
    logic [14:0]         diff_reg [S_D3:S_EF];
    logic [14:0]         diff_next;
    logic signed [47:0]  rprod_reg [3];
    logic signed [47:0]  rprod_next [3];
    logic signed [19:0]  r_reg [3];
    logic signed [19:0]  r_next [3];
    logic signed [35:0]  vr_reg [3];
    logic signed [35:0]  vr_next [3];
    logic signed [39:0]  dotvr_reg;
    logic [14:0]         base_reg;
    logic [14:0]         base_next;
    pw_t                 lg_reg [0:plsu_pkg::LOG_ROUNDS];
    pw_t                 lg_next [0:plsu_pkg::LOG_ROUNDS];
    ex_t                 ex_reg [0:plsu_pkg::EXP_TERMS];
    ex_t                 ex_next [0:plsu_pkg::EXP_TERMS];
    logic [14:0]         spec_reg;
    logic [14:0]         spec_next;
    logic [30:0]         a_reg [3];
    logic [30:0]         b_reg [3];
    logic [31:0]         c_reg [3];
    logic [47:0]         t_reg [3];
    plsu_pkg::out_t      o_reg;
    plsu_pkg::out_t      o_next;
    plsu_pkg::out_t      m_data_reg;
    plsu_pkg::out_t      skid_reg;
    logic                m_valid_reg;
    logic                skid_v_reg;
    logic                push;
    logic                out_free;

    // Whole pipeline advances unless the skid entry is occupied
    assign en = !skid_v_reg;
    assign s_ready = en;
    assign s_take = s_valid && en;

    // Input stage: split fields, form L = light - hit, V = -ray clamped, ambient
    always_comb begin
        logic signed [25:0] rw;
        logic signed [25:0] t;
        for (int i = 0; i < 3; i++) begin
            nv_next[i] = plsu_pkg::cmp_at(s_data.surface_normal, i);
            lv_next[i] = plsu_pkg::cmp_at(s_data.light_position, i)
                       - plsu_pkg::cmp_at(s_data.surface_position, i);
            rw = 26'(plsu_pkg::cmp_at(s_data.ray_direction, i));
            t = -(rw <<< 4);
            if (t > plsu_pkg::ONE_Q14) begin
                t = 26'(plsu_pkg::ONE_Q14);
            end else if (t < -plsu_pkg::ONE_Q14) begin
                t = -26'(plsu_pkg::ONE_Q14);
            end
            sd_next.v[i] = 16'(t);
            sd_next.amb[i] = 32'(scene_amb_reg[16*i +: 16])
                           * 32'(s_data.material_ambient[16*i +: 16]);
        end
        sd_next.lc = s_data.light_color;
        sd_next.kd = s_data.material_diffuse;
        sd_next.ks = s_data.material_specular;
        sd_next.e = s_data.shininess;
    end

    plsu_norm u_norm_n (
        .aclk  (aclk),
        .en    (en),
        .vec   (nv_reg),
        .u_out (n_u)
    );

    plsu_norm u_norm_l (
        .aclk  (aclk),
        .en    (en),
        .vec   (lv_reg),
        .u_out (l_u)
    );

    // Diffuse term, reflection R = 2(N.L)N - L, and specular base clamp(V.R)
    always_comb begin
        logic signed [63:0] rd;
        logic signed [63:0] rb;
        rd = plsu_pkg::rnd_shr(64'(d28_reg), 14);
        if (rd < 0) begin
            diff_next = '0;
        end else if (rd > plsu_pkg::ONE_Q14) begin
            diff_next = 15'(plsu_pkg::ONE_Q14);
        end else begin
            diff_next = 15'(rd);
        end
        for (int i = 0; i < 3; i++) begin
            rprod_next[i] = 48'(d28_reg) * 48'(n_d2_reg[i]) * 48'(plsu_pkg::REFLECT_GAIN);
            r_next[i] = 20'(plsu_pkg::rnd_shr(64'(rprod_reg[i]), 28))
                      - 20'(l_d3_reg[i]);
            vr_next[i] = 36'($signed(sd_reg[S_D4].v[i])) * 36'(r_reg[i]);
        end
        rb = plsu_pkg::rnd_shr(64'(dotvr_reg), 14);
        if (rb < 0) begin
            base_next = '0;
        end else if (rb > plsu_pkg::ONE_Q14) begin
            base_next = 15'(plsu_pkg::ONE_Q14);
        end else begin
            base_next = 15'(rb);
        end
    end

    // Specular power: normalize, 16 squaring rounds for log2, then exp2 products
    always_comb begin
        logic [14:0] x;
        logic [15:0] e;
        logic [29:0] sq;
        logic [15:0] y2;
        logic [19:0] nl;
        logic [35:0] p;
        logic [46:0] pr;
        logic [4:0]  sh;
        logic [31:0] rr;
        x = base_reg;
        e = sd_reg[S_D7].e;
        lg_next[0].fo = (e == '0) || (x >= 15'(plsu_pkg::ONE_Q14));
        lg_next[0].fz = !lg_next[0].fo && (x == '0);
        lg_next[0].k = '0;
        for (int b = 0; b < 14; b++) begin
            if (x[b]) begin
                lg_next[0].k = 4'(14 - b);
            end
        end
        lg_next[0].y = 15'(x << lg_next[0].k);
        lg_next[0].f = '0;
        for (int j = 1; j <= plsu_pkg::LOG_ROUNDS; j++) begin
            lg_next[j] = lg_reg[j-1];
            sq = 30'(lg_reg[j-1].y) * 30'(lg_reg[j-1].y);
            y2 = sq[29:14];
            lg_next[j].y = y2[15] ? y2[15:1] : y2[14:0];
            lg_next[j].f = {lg_reg[j-1].f[14:0], y2[15]};
        end

        nl = 20'({lg_reg[plsu_pkg::LOG_ROUNDS].k, 16'h0000})
           - 20'(lg_reg[plsu_pkg::LOG_ROUNDS].f);
        p = 36'(nl) * 36'(sd_reg[S_LG].e);
        ex_next[0].acc = 31'(1) << 30;
        ex_next[0].fp = p[23:8];
        ex_next[0].ip = p[27:24];
        ex_next[0].fo = lg_reg[plsu_pkg::LOG_ROUNDS].fo;
        ex_next[0].fz = lg_reg[plsu_pkg::LOG_ROUNDS].fz || (p[35:24] >= 12'd15);
        for (int j = 1; j <= plsu_pkg::EXP_TERMS; j++) begin
            ex_next[j] = ex_reg[j-1];
            pr = 47'(ex_reg[j-1].acc) * 47'(plsu_pkg::exp2_neg(4'(j - 1)));
            if (ex_reg[j-1].fp[16-j]) begin
                ex_next[j].acc = 31'(pr >> 16);
            end
        end

        sh = 5'd16 + 5'(ex_reg[plsu_pkg::EXP_TERMS].ip);
        rr = (32'(ex_reg[plsu_pkg::EXP_TERMS].acc) + (32'd1 << (sh - 5'd1))) >> sh;
        if (ex_reg[plsu_pkg::EXP_TERMS].fo) begin
            spec_next = 15'(plsu_pkg::ONE_Q14);
        end else if (ex_reg[plsu_pkg::EXP_TERMS].fz) begin
            spec_next = '0;
        end else if (rr > 32'(plsu_pkg::ONE_Q14)) begin
            spec_next = 15'(plsu_pkg::ONE_Q14);
        end else begin
            spec_next = 15'(rr);
        end
    end

    // Final channel sum in Q.44, round to Q4.12 and saturate
    always_comb begin
        logic [48:0] sum;
        logic [16:0] o;
        logic [15:0] ch [3];
        for (int i = 0; i < 3; i++) begin
            sum = (49'(sd_reg[S_C3].amb[i]) << 14) + 49'(t_reg[i]);
            o = 17'((sum + (49'd1 << 31)) >> 32);
            ch[i] = o[16] ? 16'hFFFF : o[15:0];
        end
        o_next.red = ch[0];
        o_next.green = ch[1];
        o_next.blue = ch[2];
    end

    // Payload pipeline: hold everything while en is low
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= sd_next;
            for (int s = 1; s < DEPTH; s++) begin
                sd_reg[s] <= sd_reg[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                nv_reg[i] <= nv_next[i];
                lv_reg[i] <= lv_next[i];
                n_d1_reg[i] <= n_u[i];
                n_d2_reg[i] <= n_d1_reg[i];
                l_d1_reg[i] <= l_u[i];
                l_d2_reg[i] <= l_d1_reg[i];
                l_d3_reg[i] <= l_d2_reg[i];
                nl_prod_reg[i] <= 32'(n_u[i]) * 32'(l_u[i]);
                rprod_reg[i] <= rprod_next[i];
                r_reg[i] <= r_next[i];
                vr_reg[i] <= vr_next[i];
                a_reg[i] <= 31'(diff_reg[S_EF]) * 31'(sd_reg[S_EF].kd[i]);
                b_reg[i] <= 31'(spec_reg) * 31'(sd_reg[S_EF].ks[i]);
                c_reg[i] <= 32'(a_reg[i]) + 32'(b_reg[i]);
                t_reg[i] <= 48'(c_reg[i]) * 48'(sd_reg[S_C2].lc[i]);
            end
            d28_reg <= nl_prod_reg[0] + nl_prod_reg[1] + nl_prod_reg[2];
            diff_reg[S_D3] <= diff_next;
            for (int s = S_D3 + 1; s <= S_EF; s++) begin
                diff_reg[s] <= diff_reg[s-1];
            end
            dotvr_reg <= 40'(vr_reg[0]) + 40'(vr_reg[1]) + 40'(vr_reg[2]);
            base_reg <= base_next;
            lg_reg <= lg_next;
            ex_reg <= ex_next;
            spec_reg <= spec_next;
            o_reg <= o_next;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_take};
        end
    end

    // Output register plus one skid entry
    assign out_free = !m_valid_reg || m_ready;
    assign push = en && vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_v_reg) begin
                m_valid_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_v_reg ? skid_reg : o_reg;
        end else if (push) begin
            skid_reg <= o_reg;
        end
    end

    // Scene ambient register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scene_amb_reg <= '0;
        end else if (cfg_wr_en) begin
            scene_amb_reg <= cfg_wr_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // The skid entry fills only behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid entry filled without an output stall");

    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_D7] |-> base_reg <= 15'(plsu_pkg::ONE_Q14))
        else $error("specular base above 1.0");

    a_spec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_EF] |-> spec_reg <= 15'(plsu_pkg::ONE_Q14))
        else $error("specular factor above 1.0");

endmodule
